// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sine grating generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/sgg_pkg.sv =====
// Types, constants and the cosine table of the sine grating generator.
package sgg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_SIDE        = 4096;

   localparam int TABLE_SIZE   = 1 << TABLE_ADDR_BITS;
   localparam int QUARTER_BITS = PHASE_BITS - 2;
   localparam int FRAC_BITS    = QUARTER_BITS - TABLE_ADDR_BITS;
   localparam int INDEX_BITS   = TABLE_ADDR_BITS + 1;
   localparam int PROD_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int SIDE_BITS    = 13;
   localparam int COUNT_BITS   = 12;
   localparam int STEP_BITS    = 32;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_Q30    = 64'd1 << 29;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] AMPLITUDE   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_COLUMN_STEP,
      REG_ROW_STEP
   } csr_reg_type;

   typedef struct packed {
      logic [SIDE_BITS-1:0] frame_width;
      logic [SIDE_BITS-1:0] frame_height;
      logic [STEP_BITS-1:0] column_phase_step;
      logic [STEP_BITS-1:0] row_phase_step;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0] phase;
      logic                  line_end;
      logic                  frame_end;
   } pixel_type;

   typedef logic [TABLE_SIZE:0][SAMPLE_BITS-1:0] rom_type;

   // Map a programmed size to its last index: zero acts as one, oversize clamps.
   function automatic logic [COUNT_BITS-1:0] side_last(input logic [SIDE_BITS-1:0] v);
      logic [SIDE_BITS-1:0] last;
      if (v == '0) begin
         last = '0;
      end else if (v > SIDE_BITS'(MAX_SIDE)) begin
         last = SIDE_BITS'(MAX_SIDE - 1);
      end else begin
         last = v - SIDE_BITS'(1);
      end
      return last[COUNT_BITS-1:0];
   endfunction

   // Rounded Q30 product of a series term and the squared angle.
   function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + HALF_Q30) >> 30;
   endfunction

   // Taylor series cosine in Q30, clamped to [0, 1].
   function automatic logic [63:0] cos_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x2   = (x * x + HALF_Q30) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      term = q30_mul(term, x2) / 64'd2;   sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd12;  sum = sum + $signed(term);
      term = q30_mul(term, x2) / 64'd30;  sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd56;  sum = sum + $signed(term);
      term = q30_mul(term, x2) / 64'd90;  sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd132; sum = sum + $signed(term);
      term = q30_mul(term, x2) / 64'd182; sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd240; sum = sum + $signed(term);
      term = q30_mul(term, x2) / 64'd306; sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd380; sum = sum + $signed(term);
      term = q30_mul(term, x2) / 64'd462; sum = sum - $signed(term);
      term = q30_mul(term, x2) / 64'd552; sum = sum + $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return $unsigned(sum);
   endfunction

   // Quarter-wave table, with one extra entry at the quarter point itself.
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] v;
      for (int i = 0; i <= TABLE_SIZE; i++) begin
         x = (64'(i) * HALF_PI_Q30 + 64'(TABLE_SIZE / 2)) >> TABLE_ADDR_BITS;
         v = (cos_q30(x) * AMPLITUDE + HALF_Q30) >> 30;
         rom[i] = v[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam rom_type COS_ROM = build_rom();

endpackage

// ===== hw/rtl/sine_grating_generator.sv =====
// Sinusoidal grating test-pattern generator, top level.
// An accepted pixel crosses the queue and the pipe before it shows on the result ports.
// Throughput: one pixel per cycle while results are popped; four-stage interpolation pipe.
// A four-entry queue parts raster counting from the cosine pipe; push is refused only
// when that queue is full. Reset (synchronous) clears counters, accumulators, queue
// and pipe, and loads width and height 256 and both phase steps 0.
module sine_grating_generator
   import sgg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_restart_frame,
   output logic                          empty,
   input  logic                          pop,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_line_end,
   output logic                          rsp_frame_end,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   cfg_type   cfg;
   pixel_type px;
   pixel_type q_head;
   logic      px_push;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   logic      accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   sgg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sgg_raster u_raster (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .accept        (accept),
      .restart_frame (req_restart_frame),
      .px_push       (px_push),
      .px            (px)
   );

   sgg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (px_push),
      .push_data (px),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   sgg_cosine u_cosine (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .pop       (pop),
      .empty     (empty),
      .sample    (rsp_sample),
      .line_end  (rsp_line_end),
      .frame_end (rsp_frame_end)
   );

endmodule

// ===== hw/rtl/sgg_csr.sv =====
// Configuration register file with APB-style access.
module sgg_csr
   import sgg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_reg_type sel;
   logic        wr_en;

   assign sel    = csr_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (sel)
            REG_FRAME_WIDTH:  cfg_in.frame_width       = pwdata[SIDE_BITS-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height      = pwdata[SIDE_BITS-1:0];
            REG_COLUMN_STEP:  cfg_in.column_phase_step = pwdata[STEP_BITS-1:0];
            REG_ROW_STEP:     cfg_in.row_phase_step    = pwdata[STEP_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (sel)
         REG_FRAME_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: prdata = CSR_DATA_BITS'(cfg_ff.frame_height);
         REG_COLUMN_STEP:  prdata = CSR_DATA_BITS'(cfg_ff.column_phase_step);
         REG_ROW_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.row_phase_step);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= SIDE_BITS'(256);
         cfg_ff.frame_height      <= SIDE_BITS'(256);
         cfg_ff.column_phase_step <= '0;
         cfg_ff.row_phase_step    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/sgg_raster.sv =====
// Front end: raster counters and phase accumulators, one pixel per accepted tick.
`include "assert_macros.svh"
module sgg_raster
   import sgg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      accept,
   input  logic      restart_frame,
   output logic      px_push,
   output pixel_type px
);

   logic [COUNT_BITS-1:0] col_ff, col_in, col_cur;
   logic [COUNT_BITS-1:0] row_ff, row_in, row_cur;
   logic [PHASE_BITS-1:0] row_phase_ff, row_phase_in, row_phase_cur;
   logic [PHASE_BITS-1:0] pix_phase_ff, pix_phase_in, pix_phase_cur;
   logic [COUNT_BITS-1:0] col_last;
   logic [COUNT_BITS-1:0] row_last;
   logic                  le;
   logic                  fe;

   always_comb begin
      col_cur       = restart_frame ? '0 : col_ff;
      row_cur       = restart_frame ? '0 : row_ff;
      row_phase_cur = restart_frame ? '0 : row_phase_ff;
      pix_phase_cur = restart_frame ? '0 : pix_phase_ff;
      col_last      = side_last(cfg.frame_width);
      row_last      = side_last(cfg.frame_height);
      le            = col_cur >= col_last;
      fe            = le && (row_cur >= row_last);

      col_in       = col_ff;
      row_in       = row_ff;
      row_phase_in = row_phase_ff;
      pix_phase_in = pix_phase_ff;
      if (accept) begin
         if (fe) begin
            col_in       = '0;
            row_in       = '0;
            row_phase_in = '0;
            pix_phase_in = '0;
         end else if (le) begin
            // next line starts from the row accumulator stepped back
            col_in       = '0;
            row_in       = row_cur + COUNT_BITS'(1);
            row_phase_in = row_phase_cur - cfg.row_phase_step[PHASE_BITS-1:0];
            pix_phase_in = row_phase_cur - cfg.row_phase_step[PHASE_BITS-1:0];
         end else begin
            col_in       = col_cur + COUNT_BITS'(1);
            row_in       = row_cur;
            row_phase_in = row_phase_cur;
            pix_phase_in = pix_phase_cur + cfg.column_phase_step[PHASE_BITS-1:0];
         end
      end
   end

   assign px_push      = accept;
   assign px.phase     = pix_phase_cur;
   assign px.line_end  = le;
   assign px.frame_end = fe;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         row_phase_ff <= '0;
         pix_phase_ff <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_phase_ff <= row_phase_in;
         pix_phase_ff <= pix_phase_in;
      end
   end

   `ASSERT_AT(a_frame_wrap, clock, reset, accept && fe |=> col_ff == '0 && row_ff == '0 && pix_phase_ff == '0)

endmodule

// ===== hw/rtl/sgg_fifo.sv =====
// Short queue of pixel phases between the raster front end and the cosine back end.
`include "assert_macros.svh"
module sgg_fifo
   import sgg_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  pixel_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      empty,
   output pixel_type head
);

   pixel_type                mem [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [FIFO_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   assign full  = count_ff == FIFO_CNT_BITS'(FIFO_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + FIFO_PTR_BITS'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + FIFO_PTR_BITS'(1) : rptr_ff;
      count_in = count_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   `ASSERT_NEVER(a_fifo_over, clock, reset, count_ff > FIFO_CNT_BITS'(FIFO_DEPTH))
   `ASSERT_NEVER(a_fifo_under, clock, reset, pop && count_ff == '0)

endmodule

// ===== hw/rtl/sgg_cosine.sv =====
// Back end: quarter-wave table lookup with linear interpolation, four stages.
`include "assert_macros.svh"
module sgg_cosine
   import sgg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  pixel_type                     q_head,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic signed [SAMPLE_BITS-1:0] sample,
   output logic                          line_end,
   output logic                          frame_end
);

   logic                    en;

   // stage 1: table addresses and fraction
   logic                    v1_ff;
   logic [INDEX_BITS-1:0]   idx_a_ff, idx_a_in;
   logic [INDEX_BITS-1:0]   idx_b_ff, idx_b_in;
   logic [FRAC_BITS-1:0]    frac1_ff, frac1_in;
   logic                    neg1_ff, le1_ff, fe1_ff;
   logic [1:0]              quad;
   logic [QUARTER_BITS:0]   off;

   // stage 2: table values and difference
   logic                    v2_ff;
   logic [SAMPLE_BITS-1:0]  a2_ff, d2_ff, d2_in;
   logic [SAMPLE_BITS-1:0]  tab_a, tab_b;
   logic [FRAC_BITS-1:0]    frac2_ff;
   logic                    dec2_ff, dec2_in, neg2_ff, le2_ff, fe2_ff;

   // stage 3: interpolation product
   logic                    v3_ff;
   logic [SAMPLE_BITS-1:0]  a3_ff;
   logic [PROD_BITS-1:0]    prod3_ff, prod3_in;
   logic                    dec3_ff, neg3_ff, le3_ff, fe3_ff;

   // stage 4: result register
   logic                    v4_ff;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                    le4_ff, fe4_ff;
   logic [PROD_BITS:0]      rounded;
   logic [SAMPLE_BITS-1:0]  adj;
   logic [SAMPLE_BITS-1:0]  mag;

   // advance the whole pipe unless a finished result is still waiting
   assign en    = !v4_ff || pop;
   assign q_pop = en && !q_empty;

   always_comb begin
      quad = q_head.phase[PHASE_BITS-1 -: 2];
      if (quad[0]) begin
         off = {1'b1, {QUARTER_BITS{1'b0}}} - {1'b0, q_head.phase[QUARTER_BITS-1:0]};
      end else begin
         off = {1'b0, q_head.phase[QUARTER_BITS-1:0]};
      end
      idx_a_in = off[QUARTER_BITS -: INDEX_BITS];
      frac1_in = off[FRAC_BITS-1:0];
      // the quarter point itself has no next entry; its fraction is zero
      idx_b_in = idx_a_in[INDEX_BITS-1] ? idx_a_in : idx_a_in + INDEX_BITS'(1);
   end

   always_comb begin
      tab_a   = COS_ROM[idx_a_ff];
      tab_b   = COS_ROM[idx_b_ff];
      dec2_in = tab_a >= tab_b;
      d2_in   = dec2_in ? tab_a - tab_b : tab_b - tab_a;
   end

   assign prod3_in = PROD_BITS'(d2_ff) * PROD_BITS'(frac2_ff);

   always_comb begin
      rounded   = {1'b0, prod3_ff} + ((PROD_BITS + 1)'(1) << (FRAC_BITS - 1));
      adj       = rounded[FRAC_BITS +: SAMPLE_BITS];
      mag       = dec3_ff ? a3_ff - adj : a3_ff + adj;
      sample_in = neg3_ff ? SAMPLE_BITS'(0) - mag : mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx_a_ff  <= idx_a_in;
         idx_b_ff  <= idx_b_in;
         frac1_ff  <= frac1_in;
         neg1_ff   <= quad[1] ^ quad[0];
         le1_ff    <= q_head.line_end;
         fe1_ff    <= q_head.frame_end;
         a2_ff     <= tab_a;
         d2_ff     <= d2_in;
         dec2_ff   <= dec2_in;
         frac2_ff  <= frac1_ff;
         neg2_ff   <= neg1_ff;
         le2_ff    <= le1_ff;
         fe2_ff    <= fe1_ff;
         a3_ff     <= a2_ff;
         prod3_ff  <= prod3_in;
         dec3_ff   <= dec2_ff;
         neg3_ff   <= neg2_ff;
         le3_ff    <= le2_ff;
         fe3_ff    <= fe2_ff;
         sample_ff <= sample_in;
         le4_ff    <= le3_ff;
         fe4_ff    <= fe3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign empty     = !v4_ff;
   assign sample    = $signed(sample_ff);
   assign line_end  = le4_ff;
   assign frame_end = fe4_ff;

   `ASSERT_AT(a_mark_order, clock, reset, v4_ff && fe4_ff |-> le4_ff)
   `ASSERT_NEVER(a_sample_range, clock, reset, v4_ff && sample_ff == (SAMPLE_BITS'(1) << 15))
   `ASSERT_AT(a_result_held, clock, reset, v4_ff && !pop |=> v4_ff && $stable(sample_ff))

endmodule
